[hdl/calendar_date_to_epoch_seconds_assert.svh]
// Assertion macros for the date to epoch seconds RTL.
`ifndef CALENDAR_DATE_TO_EPOCH_SECONDS_ASSERT_SVH
`define CALENDAR_DATE_TO_EPOCH_SECONDS_ASSERT_SVH
`ifndef SYNTH
`define CDTE_ASSERT_IMPLIES(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("implication check failed");
`define CDTE_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("next cycle check failed");
`else
`define CDTE_ASSERT_IMPLIES(label, clk, rst_n, cond, prop)
`define CDTE_ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif
`endif

[hdl/cdte_pkg.sv]
// Types, constants and the month table for the date to epoch seconds converter.
`default_nettype none
package cdte_pkg;

    typedef struct packed {
        logic [5:0]  second;
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [4:0]  day_of_month;
        logic [3:0]  month_number;
        logic [13:0] year_number;
    } date_t;

    typedef struct packed {
        logic [37:0] epoch_seconds;
        logic        range_error;
    } result_t;

    localparam int DAYS_W = 22;
    localparam int SOD_W = 17;
    localparam int Q100_W = 8;
    localparam int DIV100_SHIFT = 19;
    localparam int DIV100_PROD_W = 27;

    localparam logic [13:0] EPOCH_YEAR = 14'd1970;
    localparam logic [13:0] LAST_YEAR = 14'd9999;
    localparam logic [12:0] DIV100_MUL = 13'd5243;
    localparam logic [13:0] CENTURY = 14'd100;
    localparam logic [DAYS_W-1:0] DAYS_PER_YEAR = 22'd365;
    localparam logic [DAYS_W-1:0] LEAPS_BEFORE_EPOCH = 22'd477;
    localparam logic [16:0] SECS_PER_DAY = 17'd86400;
    localparam logic [SOD_W-1:0] SECS_PER_HOUR = 17'd3600;
    localparam logic [SOD_W-1:0] SECS_PER_MIN = 17'd60;
    localparam logic [5:0] MAX_SECOND = 6'd59;
    localparam logic [5:0] MAX_MINUTE = 6'd59;
    localparam logic [4:0] MAX_HOUR = 5'd23;
    localparam logic [3:0] MONTH_JAN = 4'd1;
    localparam logic [3:0] MONTH_MAR = 4'd3;
    localparam logic [3:0] MONTH_DEC = 4'd12;
    localparam logic [37:0] MAX_EPOCH = 38'd253402300799;

    function automatic logic [8:0] month_start(input logic [3:0] mon);
        logic [8:0] d;
        case (mon)
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage
`default_nettype wire

[hdl/calendar_date_to_epoch_seconds.sv]
// A result appears on result with done high once the date has passed the date_reg, day count and result_reg stages.
// Throughput: one item per cycle; the four register stages never stall, so busy stays low.
// The day count stage, a reciprocal multiply and a 365 day multiply, sets the stage depth.
// Reset clears every valid bit and done; payload registers are not reset.
// Out of range second, minute, hour, month or year fields, or a zero day, give range_error high and zero seconds.
`default_nettype none
`include "calendar_date_to_epoch_seconds_assert.svh"
module calendar_date_to_epoch_seconds (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire cdte_pkg::date_t     date,
    output logic                     done,
    output cdte_pkg::result_t        result
);

    cdte_pkg::date_t                date_reg;
    logic                           v1_reg;
    logic                           v2_reg;
    logic                           v3_reg;
    logic                           done_reg;
    logic                           err_next;
    logic                           err1_reg;
    logic                           err2_reg;
    logic                           err3_reg;
    logic [cdte_pkg::SOD_W-1:0]     sod_next;
    logic [cdte_pkg::SOD_W-1:0]     sod2_reg;
    logic [cdte_pkg::SOD_W-1:0]     sod3_reg;
    logic [cdte_pkg::DAYS_W-1:0]    days;
    logic [37:0]                    total_next;
    cdte_pkg::result_t              result_reg;
    cdte_pkg::result_t              result_next;

    assign busy = 1'b0;

    always_comb
    begin
        err_next = (date.second > cdte_pkg::MAX_SECOND)
                || (date.minute > cdte_pkg::MAX_MINUTE)
                || (date.hour > cdte_pkg::MAX_HOUR)
                || (date.day_of_month == 5'd0)
                || (date.month_number < cdte_pkg::MONTH_JAN)
                || (date.month_number > cdte_pkg::MONTH_DEC)
                || (date.year_number < cdte_pkg::EPOCH_YEAR)
                || (date.year_number > cdte_pkg::LAST_YEAR);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= start && !busy;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            done_reg <= v3_reg;
        end
    end

    always_comb
    begin
        sod_next = cdte_pkg::SOD_W'(date_reg.hour) * cdte_pkg::SECS_PER_HOUR
                 + cdte_pkg::SOD_W'(date_reg.minute) * cdte_pkg::SECS_PER_MIN
                 + cdte_pkg::SOD_W'(date_reg.second);
    end

    cdte_day_count u_day_count (
        .clk  (clk),
        .date (date_reg),
        .days (days)
    );

    always_comb
    begin
        total_next = 38'(days) * 38'(cdte_pkg::SECS_PER_DAY) + 38'(sod3_reg);
        result_next.range_error = err3_reg;
        result_next.epoch_seconds = err3_reg ? 38'd0 : total_next;
    end

    always_ff @(posedge clk)
    begin
        date_reg   <= date;
        err1_reg   <= err_next;
        err2_reg   <= err1_reg;
        err3_reg   <= err2_reg;
        sod2_reg   <= sod_next;
        sod3_reg   <= sod2_reg;
        result_reg <= result_next;
    end

    assign done = done_reg;
    assign result = result_reg;

    `CDTE_ASSERT_NEXT(a_valid_to_done, clk, rst_n, v3_reg, done)
    `CDTE_ASSERT_NEXT(a_idle_no_done, clk, rst_n, !v3_reg, !done)
    `CDTE_ASSERT_IMPLIES(a_error_zero, clk, rst_n, done && result.range_error, result.epoch_seconds == 38'd0)
    `CDTE_ASSERT_IMPLIES(a_seconds_bound, clk, rst_n, done, result.epoch_seconds <= cdte_pkg::MAX_EPOCH)

endmodule
`default_nettype wire

[hdl/cdte_day_count.sv]
// Two stage pipeline that turns year, month and day into days since the epoch.
`default_nettype none
module cdte_day_count (
    input  wire logic                        clk,
    input  wire cdte_pkg::date_t             date,
    output logic [cdte_pkg::DAYS_W-1:0]      days
);

    logic [13:0]                           yr_reg;
    logic [3:0]                            mon_reg;
    logic [4:0]                            day_reg;
    logic [cdte_pkg::Q100_W-1:0]           q100_reg;
    logic [cdte_pkg::Q100_W-1:0]           q100_next;
    logic [cdte_pkg::DIV100_PROD_W-1:0]    div_prod;
    logic [cdte_pkg::DAYS_W-1:0]           days_reg;
    logic [cdte_pkg::DAYS_W-1:0]           days_next;
    logic                                  leap;
    logic [12:0]                           leaps_thru;
    logic [12:0]                           leaps_prev;
    logic [13:0]                           year_off;
    logic [cdte_pkg::DAYS_W-1:0]           year_days;
    logic                                  after_feb;

    // Division by 100 as a multiply by the scaled reciprocal; exact for every 14-bit year.
    assign div_prod = cdte_pkg::DIV100_PROD_W'(date.year_number)
                    * cdte_pkg::DIV100_PROD_W'(cdte_pkg::DIV100_MUL);
    assign q100_next = div_prod[cdte_pkg::DIV100_PROD_W-1:cdte_pkg::DIV100_SHIFT];

    always_ff @(posedge clk)
    begin
        yr_reg   <= date.year_number;
        mon_reg  <= date.month_number;
        day_reg  <= date.day_of_month;
        q100_reg <= q100_next;
    end

    always_comb
    begin
        leap = (yr_reg[1:0] == 2'b00)
            && (((14'(q100_reg) * cdte_pkg::CENTURY) != yr_reg) || (q100_reg[1:0] == 2'b00));
        leaps_thru = 13'(yr_reg[13:2]) - 13'(q100_reg) + 13'(q100_reg[cdte_pkg::Q100_W-1:2]);
        leaps_prev = leaps_thru - 13'(leap);
        year_off = yr_reg - cdte_pkg::EPOCH_YEAR;
        year_days = cdte_pkg::DAYS_W'(year_off) * cdte_pkg::DAYS_PER_YEAR;
        after_feb = leap && (mon_reg >= cdte_pkg::MONTH_MAR);
        days_next = year_days
                  + cdte_pkg::DAYS_W'(leaps_prev)
                  - cdte_pkg::LEAPS_BEFORE_EPOCH
                  + cdte_pkg::DAYS_W'(cdte_pkg::month_start(mon_reg))
                  + cdte_pkg::DAYS_W'(after_feb)
                  + cdte_pkg::DAYS_W'(day_reg)
                  - cdte_pkg::DAYS_W'(1);
    end

    always_ff @(posedge clk)
    begin
        days_reg <= days_next;
    end

    assign days = days_reg;

endmodule
`default_nettype wire
